// ===== hdl/eitp_pkg.sv =====
`timescale 1ns / 1ps
// eitp_pkg: constants and widths shared by the ethernet/ipv4/tcp header parser
// no dependencies

package eitp_pkg;

  localparam int unsigned CountW     = 7;
  localparam int unsigned TcpHdrLen  = 20;
  localparam int unsigned TcpIdxW    = 5;
  localparam int unsigned OutDataW   = 160;

  localparam logic [CountW-1:0] EthHdrLen    = 7'd14;
  localparam logic [CountW-1:0] MinFrameLen  = 7'd34;
  localparam logic [CountW-1:0] CountMax     = 7'd127;
  localparam logic [CountW-1:0] TcpHdrLenC   = 7'd20;
  localparam logic [CountW-1:0] PosKindHi    = 7'd12;
  localparam logic [CountW-1:0] PosKindLo    = 7'd13;
  localparam logic [CountW-1:0] PosIhl       = 7'd14;
  localparam logic [CountW-1:0] PosProto     = 7'd23;
  localparam logic [15:0]       Ipv4Kind     = 16'h0800;
  localparam logic [7:0]        TcpProto     = 8'd6;

  typedef logic [7:0] byte_t;

endpackage

// ===== hdl/ethernet_ipv4_tcp_header_parser.sv =====
`timescale 1ns / 1ps
// ethernet_ipv4_tcp_header_parser: byte-serial frame parser with tcp header result
// depends on eitp_pkg

// usage
// s_axis carries one frame byte per request, tlast on the final byte of the frame.
// m_axis carries one result per frame, issued for the request that had tlast set;
// tuser is the header valid flag, tdata the tcp header fields (zero when invalid).
// a byte is accepted in any cycle in which s_axis_tvalid and s_axis_tready are both high.
// the result is registered into the result register, or into the skid register while a result waits.
// bytes flow at one byte per cycle while s_axis_tready stays high, with a single state update per byte.
// a two-entry output stage (result register plus skid register) lets bytes keep
// flowing while a result waits; s_axis_tready drops only once both entries hold
// results the receiver has not taken.
// reset (rst, synchronous) clears the byte count, the captured ethertype and
// protocol, sets the tcp offset to 14 and empties the output stage.

module ethernet_ipv4_tcp_header_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // data_byte
  input  logic                          s_axis_tlast,  // last_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // source_port, destination_port, sequence_number, acknowledge_number,
  // header_words, flag_bits, rx_window, tcp_checksum, urgent_offset, zero pad
  output logic [eitp_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tuser   // header_valid
);
  import eitp_pkg::*;

  logic [CountW-1:0] byte_count, byte_count_next;
  logic [15:0]       ether_kind, ether_kind_next;
  byte_t             ip_proto, ip_proto_next;
  logic [CountW-1:0] tcp_start, tcp_start_next;
  byte_t             tcp_bytes [TcpHdrLen];
  byte_t             tcp_bytes_next [TcpHdrLen];

  logic [CountW-1:0] pos, len, tcp_end;
  logic [CountW-1:0] rel;
  logic              in_tcp, accept, res_valid, hdr_ok;
  logic [OutDataW-1:0] res_data;

  logic                sk_valid;
  logic [OutDataW-1:0] sk_data;
  logic                sk_user;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !sk_valid;
  assign pos = byte_count;

  always_comb begin
    ether_kind_next = ether_kind;
    ip_proto_next   = ip_proto;
    tcp_start_next  = tcp_start;
    if (pos == PosKindHi) begin
      ether_kind_next = {s_axis_tdata, ether_kind[7:0]};
    end else if (pos == PosKindLo) begin
      ether_kind_next = {ether_kind[15:8], s_axis_tdata};
    end else if (pos == PosProto) begin
      ip_proto_next = s_axis_tdata;
    end
    if (pos == PosIhl) begin
      tcp_start_next = EthHdrLen + {1'b0, s_axis_tdata[3:0], 2'b00};
    end
  end

  assign tcp_end = tcp_start_next + TcpHdrLenC;
  assign in_tcp  = (pos >= tcp_start_next) && (pos < tcp_end);
  assign rel     = pos - tcp_start_next;

  always_comb begin
    for (int i = 0; i < TcpHdrLen; i++) begin
      tcp_bytes_next[i] = tcp_bytes[i];
    end
    if (in_tcp) begin
      tcp_bytes_next[rel[TcpIdxW-1:0]] = s_axis_tdata;
    end
  end

  assign len = (byte_count < CountMax) ? byte_count + 7'd1 : CountMax;

  always_comb begin
    byte_count_next = len;
    if (s_axis_tlast) begin
      byte_count_next = '0;
    end
  end

  assign res_valid = accept && s_axis_tlast;
  assign hdr_ok = (len >= MinFrameLen) && (ether_kind_next == Ipv4Kind) &&
                  (ip_proto_next == TcpProto) && (len >= tcp_end);

  always_comb begin
    res_data = '0;
    if (hdr_ok) begin
      res_data = {4'b0000,
                  tcp_bytes_next[18], tcp_bytes_next[19],
                  tcp_bytes_next[16], tcp_bytes_next[17],
                  tcp_bytes_next[14], tcp_bytes_next[15],
                  tcp_bytes_next[13],
                  tcp_bytes_next[12][7:4],
                  tcp_bytes_next[8], tcp_bytes_next[9],
                  tcp_bytes_next[10], tcp_bytes_next[11],
                  tcp_bytes_next[4], tcp_bytes_next[5],
                  tcp_bytes_next[6], tcp_bytes_next[7],
                  tcp_bytes_next[2], tcp_bytes_next[3],
                  tcp_bytes_next[0], tcp_bytes_next[1]};
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      ether_kind <= '0;
      ip_proto   <= '0;
      tcp_start  <= EthHdrLen;
    end else if (accept) begin
      byte_count <= byte_count_next;
      ether_kind <= ether_kind_next;
      ip_proto   <= ip_proto_next;
      tcp_start  <= s_axis_tlast ? EthHdrLen : tcp_start_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < TcpHdrLen; i++) begin
        tcp_bytes[i] <= tcp_bytes_next[i];
      end
    end
  end

  // result register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      sk_valid      <= 1'b0;
    end else if (m_axis_tvalid && !m_axis_tready) begin
      if (res_valid) begin
        sk_valid <= 1'b1;
      end
    end else if (sk_valid) begin
      m_axis_tvalid <= 1'b1;
      sk_valid      <= res_valid;
    end else begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tvalid && !m_axis_tready) begin
      if (res_valid) begin
        sk_data <= res_data;
        sk_user <= hdr_ok;
      end
    end else if (sk_valid) begin
      m_axis_tdata <= sk_data;
      m_axis_tuser <= sk_user;
      sk_data      <= res_data;
      sk_user      <= hdr_ok;
    end else begin
      m_axis_tdata <= res_data;
      m_axis_tuser <= hdr_ok;
    end
  end

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> m_axis_tvalid)
    else $error("skid entry held without a result in the output register");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("invalid result carries nonzero fields");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && s_axis_tlast) |=> (byte_count == '0 && tcp_start == EthHdrLen))
    else $error("parser state not restarted after last byte");

  a_tcp_start_range: assert property (@(posedge clk) disable iff (rst)
    (tcp_start >= EthHdrLen) && (tcp_start <= 7'd74))
    else $error("tcp offset out of range");

  a_result_on_last: assert property (@(posedge clk) disable iff (rst)
    (!sk_valid && !m_axis_tvalid && !(accept && s_axis_tlast)) |=> !m_axis_tvalid)
    else $error("result issued without a last byte");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: random and directed frame test for ethernet_ipv4_tcp_header_parser
// holds a scoreboard class that predicts one header result per frame
// depends on eitp_pkg and the parser rtl

module tb_top;
  import eitp_pkg::*;

  localparam int ByteTarget   = 1850;
  localparam int HoldCycles   = 400;
  localparam int IdleLimit    = 2000;
  localparam int SettleCycles = 10;
  localparam int MaxReports   = 50;

  typedef struct packed {
    logic        valid;
    logic [15:0] from_port;
    logic [15:0] to_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [3:0]  data_words;
    logic [7:0]  flags;
    logic [15:0] window;
    logic [15:0] checksum;
    logic [15:0] urgent;
  } tcp_fields_t;

  class tcp_header_board;
    logic [CountW-1:0] byte_count;
    logic [15:0]       ether_kind;
    logic [7:0]        ip_proto;
    logic [CountW-1:0] tcp_start;
    byte_t             tcp_bytes [TcpHdrLen];
    tcp_fields_t       header_q [$];
    int                failures;
    int                frames;
    int                valid_frames;
    int                reports;

    function new();
      byte_count = '0;
      ether_kind = '0;
      ip_proto   = '0;
      tcp_start  = EthHdrLen;
      foreach (tcp_bytes[i]) tcp_bytes[i] = '0;
      failures = 0;
      frames = 0;
      valid_frames = 0;
      reports = 0;
    endfunction

    function int pending();
      return header_q.size();
    endfunction

    // accepted request: advance the parse state, queue a header on the last byte
    function void note_byte(byte_t b, bit last);
      int          pos;
      int          len;
      tcp_fields_t hdr;
      pos = int'(byte_count);
      if (pos == int'(PosKindHi)) ether_kind[15:8] = b;
      else if (pos == int'(PosKindLo)) ether_kind[7:0] = b;
      else if (pos == int'(PosProto)) ip_proto = b;
      if (pos == int'(PosIhl)) tcp_start = EthHdrLen + {1'b0, b[3:0], 2'b00};
      if (pos >= int'(tcp_start) && pos < int'(tcp_start) + TcpHdrLen)
        tcp_bytes[pos - int'(tcp_start)] = b;
      len = (byte_count < CountMax) ? pos + 1 : int'(CountMax);
      byte_count = CountW'(len);
      if (!last) return;
      hdr = '0;
      if (len >= int'(MinFrameLen) && ether_kind == Ipv4Kind && ip_proto == TcpProto &&
          len >= int'(tcp_start) + TcpHdrLen) begin
        hdr.valid      = 1'b1;
        hdr.from_port  = {tcp_bytes[0], tcp_bytes[1]};
        hdr.to_port    = {tcp_bytes[2], tcp_bytes[3]};
        hdr.seq_num    = {tcp_bytes[4], tcp_bytes[5], tcp_bytes[6], tcp_bytes[7]};
        hdr.ack_num    = {tcp_bytes[8], tcp_bytes[9], tcp_bytes[10], tcp_bytes[11]};
        hdr.data_words = tcp_bytes[12][7:4];
        hdr.flags      = tcp_bytes[13];
        hdr.window     = {tcp_bytes[14], tcp_bytes[15]};
        hdr.checksum   = {tcp_bytes[16], tcp_bytes[17]};
        hdr.urgent     = {tcp_bytes[18], tcp_bytes[19]};
        valid_frames++;
      end
      frames++;
      header_q.push_back(hdr);
      byte_count = '0;
      tcp_start  = EthHdrLen;
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (want === got) return 1'b1;
      if (reports < MaxReports)
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      reports++;
      return 1'b0;
    endfunction

    function void check_result(logic [OutDataW-1:0] data, logic user);
      tcp_fields_t want;
      tcp_fields_t got;
      bit          ok;
      if (header_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual tuser %b tdata %h",
                 $time, user, data);
        failures++;
        return;
      end
      want = header_q.pop_front();
      got.valid      = user;
      got.from_port  = data[15:0];
      got.to_port    = data[31:16];
      got.seq_num    = data[63:32];
      got.ack_num    = data[95:64];
      got.data_words = data[99:96];
      got.flags      = data[107:100];
      got.window     = data[123:108];
      got.checksum   = data[139:124];
      got.urgent     = data[155:140];
      ok = field_ok("header_valid", 32'(want.valid), 32'(got.valid));
      ok &= field_ok("source_port", 32'(want.from_port), 32'(got.from_port));
      ok &= field_ok("destination_port", 32'(want.to_port), 32'(got.to_port));
      ok &= field_ok("sequence_number", want.seq_num, got.seq_num);
      ok &= field_ok("acknowledge_number", want.ack_num, got.ack_num);
      ok &= field_ok("header_words", 32'(want.data_words), 32'(got.data_words));
      ok &= field_ok("flag_bits", 32'(want.flags), 32'(got.flags));
      ok &= field_ok("rx_window", 32'(want.window), 32'(got.window));
      ok &= field_ok("tcp_checksum", 32'(want.checksum), 32'(got.checksum));
      ok &= field_ok("urgent_offset", 32'(want.urgent), 32'(got.urgent));
      if (!ok) failures++;
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  tcp_header_board board;
  bit              hold_req = 1'b0;
  bit              hold_done = 1'b0;
  int              bytes_sent = 0;
  int              idle_cycles = 0;

  always #5 clk = ~clk;

  ethernet_ipv4_tcp_header_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  task automatic send_frame(input byte_t frame_q[$], input bit burst);
    int k;
    int r;
    int gap;
    for (k = 0; k < frame_q.size(); k++) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= frame_q[k];
      s_axis_tlast  <= (k == frame_q.size() - 1);
      @(posedge clk);
      while (!s_axis_tready) @(posedge clk);
      board.note_byte(frame_q[k], k == frame_q.size() - 1);
      bytes_sent++;
      r = $urandom_range(0, 99);
      gap = (burst || r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // result side: random ready stretches, plus one long hold-off on request
  initial begin
    int mode;
    int run;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        run = $urandom_range(1, 40);
        repeat (run) begin
          case (mode)
            0: begin
              m_axis_tready <= 1'b1;
            end
            1: begin
              m_axis_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
              m_axis_tready <= ($urandom_range(0, 19) != 0);
            end
            default: begin
              m_axis_tready <= 1'b0;
            end
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d cycles with no request accepted", idle_cycles);
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    byte_t       frame_q[$];
    int          frame_no;
    int          kind;
    int          ihl;
    int          need;
    int          payload;
    int          n;
    int          r;
    logic [15:0] flip;
    board = new();
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-byte frames at both data extremes
    frame_q = '{8'h00};
    send_frame(frame_q, 1'b1);
    frame_q = '{8'hff};
    send_frame(frame_q, 1'b0);
    // ihl of zero: tcp header overlaps the ip header, all-ones content
    frame_q.delete();
    repeat (34) frame_q.push_back(8'hff);
    frame_q[12] = 8'h08;
    frame_q[13] = 8'h00;
    frame_q[14] = 8'hf0;
    frame_q[23] = TcpProto;
    send_frame(frame_q, 1'b1);

    frame_no = 0;
    while (bytes_sent < ByteTarget) begin
      frame_no++;
      if (frame_no == 4) hold_req = 1'b1;
      if (frame_no == 20) drain_results();
      frame_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 90) begin
        ihl = $urandom_range(0, 1) ? 5 : $urandom_range(0, 15);
        need = int'(EthHdrLen) + 4 * ihl + TcpHdrLen;
        r = $urandom_range(0, 99);
        payload = (r < 85) ? $urandom_range(0, 6) :
                  (r < 95) ? $urandom_range(7, 40) : $urandom_range(60, 170);
        repeat (need + payload) frame_q.push_back(byte_t'($urandom));
        frame_q[12] = 8'h08;
        frame_q[13] = 8'h00;
        frame_q[14] = {4'($urandom), 4'(ihl)};
        frame_q[23] = TcpProto;
        if (kind >= 65 && kind < 72) begin
          flip = 16'h0001 << $urandom_range(0, 15);
          frame_q[12] ^= flip[15:8];
          frame_q[13] ^= flip[7:0];
        end else if (kind >= 72 && kind < 78) begin
          frame_q[23] ^= 8'h01 << $urandom_range(0, 7);
        end else if (kind >= 78) begin
          n = $urandom_range(1, need - 1);
          while (frame_q.size() > n) void'(frame_q.pop_back());
        end
      end else begin
        n = $urandom_range(1, 40);
        repeat (n) frame_q.push_back(byte_t'($urandom));
      end
      send_frame(frame_q, $urandom_range(0, 3) == 0);
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk);
    $display("sent %0d bytes in %0d frames, %0d of them carrying a valid tcp header",
             bytes_sent, board.frames, board.valid_frames);
    $display("frames covered short, truncated, long, noise and bad type or protocol cases");
    if (board.failures == 0 && board.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/eitp_pkg.sv
hdl/ethernet_ipv4_tcp_header_parser.sv
bench/tb_top.sv
